### hw/rtl/tensor_slot_occupancy_map_macros.svh
// Assertion helpers for the checker file.
`ifndef TENSOR_SLOT_OCCUPANCY_MAP_MACROS_SVH
`define TENSOR_SLOT_OCCUPANCY_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSOM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("occupancy map check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("occupancy map check failed");

`endif

### hw/rtl/tsom_pkg.sv
package tsom_pkg;

    // Fixed geometry of the index fields and the memory word
    localparam int NSLOT  = 4;
    localparam int DIM_W  = 8;
    localparam int WORD_W = 32;
    localparam int WB     = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_DIM_COUNT  = 3'd0;
    localparam logic [2:0] CFG_DIM_SIZE_0 = 3'd1;
    localparam logic [2:0] CFG_DIM_SIZE_1 = 3'd2;
    localparam logic [2:0] CFG_DIM_SIZE_2 = 3'd3;
    localparam logic [2:0] CFG_DIM_SIZE_3 = 3'd4;

    typedef enum logic [1:0] {
        K_MARK   = 2'd0,
        K_TEST   = 2'd1,
        K_PREFIX = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_INDEX,
        S_MODIFY,
        S_SCAN
    } t_state;

    typedef logic [NSLOT-1:0][DIM_W-1:0] t_dim_vec;

    // Request handed to the index unit at transaction accept
    typedef struct packed {
        t_dim_vec   idx;
        logic [2:0] n;
        logic [2:0] dims;
    } t_idx_req;

    // Bits lo..hi of one memory word
    function automatic logic [WORD_W-1:0] word_mask(input logic [WB-1:0] lo,
                                                     input logic [WB-1:0] hi);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (WB'(WORD_W - 1) - hi));
    endfunction

endpackage

### hw/rtl/tsom_ram.sv
module tsom_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tsom_pkg::WORD_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tsom_pkg::WORD_W-1:0] o_rdata
);

    logic [tsom_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [tsom_pkg::WORD_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tsom_index.sv
module tsom_index #(
    parameter int CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tsom_pkg::t_idx_req   i_req,
    input  tsom_pkg::t_dim_vec   i_size,
    output logic                 o_done,
    output logic [$clog2(CAPACITY)-1:0]   o_id,
    output logic [$clog2(CAPACITY+2)-1:0] o_prod,
    output logic [$clog2(CAPACITY+2)-1:0] o_stride
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 2);
    localparam int DW  = tsom_pkg::DIM_W;
    localparam int MW  = IW + DW + 1;
    localparam int PW  = CW + DW;
    localparam int SW  = $clog2(tsom_pkg::NSLOT);
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
    localparam logic [CW-1:0] SAT   = CW'(CAPACITY + 1);

    logic                r_run;
    logic                r_done;
    logic [SW-1:0]       r_step;
    tsom_pkg::t_idx_req  r_req;
    logic [IW-1:0]       r_id;
    logic [CW-1:0]       r_prod;
    logic [CW-1:0]       r_stride;

    logic [DW-1:0]       step_size;
    logic                in_prefix;
    logic [DW-1:0]       term;
    logic [MW-1:0]       id_full;
    logic [PW-1:0]       prod_full;
    logic [PW-1:0]       stride_full;
    logic [IW-1:0]       n_id;
    logic [CW-1:0]       n_prod;
    logic [CW-1:0]       n_stride;
    logic                last_step;

    // One dimension per cycle: multiply-accumulate the id, grow the products
    always_comb begin
        step_size   = i_size[r_step];
        in_prefix   = 3'(r_step) < r_req.n;
        term        = in_prefix ? r_req.idx[r_step] : '0;
        id_full     = MW'(r_id) * MW'(step_size) + MW'(term);
        prod_full   = PW'(r_prod) * PW'(step_size);
        stride_full = PW'(r_stride) * PW'(step_size);
        n_id        = IW'(id_full);
        // saturate anything above capacity so it stays out of range
        n_prod      = (prod_full > CAP_P) ? SAT : CW'(prod_full);
        if (in_prefix) begin
            n_stride = r_stride;
        end else begin
            n_stride = (stride_full > CAP_P) ? SAT : CW'(stride_full);
        end
        last_step   = (3'(r_step) + 3'd1) == r_req.dims;
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + SW'(1);
                if (last_step) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulators; hold after the last step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req    <= i_req;
            r_id     <= '0;
            r_prod   <= CW'(1);
            r_stride <= CW'(1);
        end else if (r_run) begin
            r_id     <= n_id;
            r_prod   <= n_prod;
            r_stride <= n_stride;
        end
    end

    assign o_done   = r_done;
    assign o_id     = r_id;
    assign o_prod   = r_prod;
    assign o_stride = r_stride;

endmodule

### hw/rtl/tensor_slot_occupancy_map.sv
// Slot occupancy map over a grid of up to four dimensions, one bit per slot.
// Flow: an unusable dim_count is rejected at once (a clear then goes straight to the wipe);
// otherwise the index unit walks the dims, then a range or shape reject or an empty prefix
// span reports, mark or test reads one word, a prefix check scans its words, a clear wipes all.
// One transaction at a time: the next is taken at the edge that ends the strobe.
// Synchronous reset runs a clearing pass over every memory word, busy high; no output stall.
module tensor_slot_occupancy_map #(
    parameter int MAX_DIMS = 4,
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_index_0,
    input  logic [7:0]  i_index_1,
    input  logic [7:0]  i_index_2,
    input  logic [7:0]  i_index_3,
    input  logic [2:0]  i_prefix_len,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_done,
    output logic        o_slot_marked,
    output logic        o_range_empty,
    output logic [10:0] o_marked_count,
    output logic        o_all_full,
    output logic [9:0]  o_slot_id,
    output logic        o_bad_index
);

    localparam int WORD_W = tsom_pkg::WORD_W;
    localparam int WB     = tsom_pkg::WB;
    localparam int NSLOT  = tsom_pkg::NSLOT;
    localparam int DEPTH  = (CAPACITY + WORD_W - 1) / WORD_W;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 2);
    localparam int KW     = $clog2(CAPACITY + 1);
    localparam int EW     = CW + 1;
    localparam logic [2:0] DIM_LIM = 3'((MAX_DIMS < NSLOT) ? MAX_DIMS : NSLOT);

    // Configuration registers
    logic [2:0]          r_dim_count;
    tsom_pkg::t_dim_vec  r_size;

    // Control state
    tsom_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_report, n_report;
    logic                r_valid, n_valid;
    logic [KW-1:0]       r_count, n_count;
    logic                r_chk, n_chk;
    logic                r_issued, n_issued;
    logic                r_done, n_done;

    // Payload state
    tsom_pkg::t_kind     r_kind, n_kind;
    logic                r_pre_bad, n_pre_bad;
    logic                r_hit, n_hit;
    logic [AW-1:0]       r_chk_addr, n_chk_addr;
    logic                r_marked, n_marked;
    logic                r_empty, n_empty;
    logic [IW-1:0]       r_sid, n_sid;
    logic                r_bad, n_bad;
    logic                r_full, n_full;

    // Memory port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // Index unit
    tsom_pkg::t_idx_req  ix_req;
    logic                ix_start;
    logic                ix_done;
    logic [IW-1:0]       ix_id;
    logic [CW-1:0]       ix_prod;
    logic [CW-1:0]       ix_stride;

    // Decode of the incoming transaction
    tsom_pkg::t_kind     in_kind;
    logic                accept;
    logic                dims_ok;
    logic [2:0]          in_n;
    logic                range_bad;
    logic                plen_bad;

    // Derived addressing
    logic                shape_valid;
    logic [EW-1:0]       span_end;
    logic [EW-1:0]       span_last;
    logic [AW-1:0]       first_word;
    logic [AW-1:0]       last_word;
    logic [AW-1:0]       slot_word;
    logic [WB-1:0]       slot_bit;
    logic [WB-1:0]       mask_lo;
    logic [WB-1:0]       mask_hi;
    logic                hit_now;
    logic                cur_bit;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= 3'd1;
            for (int i = 0; i < NSLOT; i++) begin
                r_size[i] <= 8'd1;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsom_pkg::CFG_DIM_COUNT:  r_dim_count <= i_cfg_data[2:0];
                tsom_pkg::CFG_DIM_SIZE_0: r_size[0]   <= i_cfg_data;
                tsom_pkg::CFG_DIM_SIZE_1: r_size[1]   <= i_cfg_data;
                tsom_pkg::CFG_DIM_SIZE_2: r_size[2]   <= i_cfg_data;
                tsom_pkg::CFG_DIM_SIZE_3: r_size[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Check the transaction against the shape
    always_comb begin
        in_kind   = tsom_pkg::t_kind'(i_kind);
        accept    = i_start && !o_busy;
        dims_ok   = (r_dim_count != 3'd0) && (r_dim_count <= DIM_LIM);
        in_n      = (in_kind == tsom_pkg::K_PREFIX) ? i_prefix_len : r_dim_count;
        plen_bad  = (in_kind == tsom_pkg::K_PREFIX) &&
                    ((i_prefix_len == 3'd0) || (i_prefix_len > r_dim_count));
        ix_req.idx  = {i_index_3, i_index_2, i_index_1, i_index_0};
        ix_req.n    = in_n;
        ix_req.dims = r_dim_count;
        range_bad = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if ((3'(i) < in_n) && (ix_req.idx[i] >= r_size[i])) begin
                range_bad = 1'b1;
            end
        end
        ix_start  = accept && dims_ok;
    end

    tsom_index #(
        .CAPACITY (CAPACITY)
    ) u_index (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ix_start),
        .i_req    (ix_req),
        .i_size   (r_size),
        .o_done   (ix_done),
        .o_id     (ix_id),
        .o_prod   (ix_prod),
        .o_stride (ix_stride)
    );

    tsom_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Word and bit positions of the slot or prefix span
    always_comb begin
        shape_valid = ix_prod <= CW'(CAPACITY);
        span_end    = EW'(ix_id) + EW'(ix_stride);
        span_last   = span_end - EW'(1);
        first_word  = AW'(ix_id >> WB);
        last_word   = AW'(span_last >> WB);
        slot_word   = first_word;
        slot_bit    = WB'(ix_id);
        mask_lo     = (r_chk_addr == first_word) ? slot_bit : '0;
        mask_hi     = (r_chk_addr == last_word) ? WB'(span_last) : '1;
        hit_now     = |(ram_rdata & tsom_pkg::word_mask(mask_lo, mask_hi));
        cur_bit     = ram_rdata[slot_bit];
    end

    // Sequencer: next state, memory accesses and result
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_report   = r_report;
        n_valid    = r_valid;
        n_count    = r_count;
        n_chk      = r_chk;
        n_issued   = r_issued;
        n_done     = 1'b0;
        n_kind     = r_kind;
        n_pre_bad  = r_pre_bad;
        n_hit      = r_hit;
        n_chk_addr = r_chk_addr;
        n_marked   = r_marked;
        n_empty    = r_empty;
        n_sid      = r_sid;
        n_bad      = r_bad;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_addr;

        case (r_state)
            tsom_pkg::S_WIPE: begin
                // zero one word a cycle
                ram_we = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = tsom_pkg::S_IDLE;
                    n_count = '0;
                    if (r_report) begin
                        n_done   = 1'b1;
                        n_marked = 1'b0;
                        n_empty  = 1'b0;
                        n_sid    = '0;
                        n_bad    = !r_valid;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tsom_pkg::S_IDLE: begin
                if (accept) begin
                    n_kind    = in_kind;
                    n_pre_bad = range_bad || plen_bad;
                    if (dims_ok) begin
                        n_state = tsom_pkg::S_INDEX;
                    end else if (in_kind == tsom_pkg::K_CLEAR) begin
                        n_state  = tsom_pkg::S_WIPE;
                        n_addr   = '0;
                        n_report = 1'b1;
                        n_valid  = 1'b0;
                    end else begin
                        // unusable shape: reject at once
                        n_done   = 1'b1;
                        n_valid  = 1'b0;
                        n_marked = 1'b0;
                        n_empty  = 1'b0;
                        n_sid    = '0;
                        n_bad    = 1'b1;
                    end
                end
            end
            tsom_pkg::S_INDEX: begin
                if (ix_done) begin
                    n_valid  = shape_valid;
                    n_marked = 1'b0;
                    n_empty  = 1'b0;
                    n_sid    = '0;
                    n_bad    = 1'b0;
                    if (r_kind == tsom_pkg::K_CLEAR) begin
                        n_state  = tsom_pkg::S_WIPE;
                        n_addr   = '0;
                        n_report = 1'b1;
                    end else if (!shape_valid || r_pre_bad) begin
                        n_state = tsom_pkg::S_IDLE;
                        n_done  = 1'b1;
                        n_bad   = 1'b1;
                    end else if (r_kind == tsom_pkg::K_PREFIX) begin
                        if (ix_stride == '0) begin
                            // empty span: nothing to scan
                            n_state = tsom_pkg::S_IDLE;
                            n_done  = 1'b1;
                            n_empty = 1'b1;
                            n_sid   = ix_id;
                        end else begin
                            n_state  = tsom_pkg::S_SCAN;
                            n_addr   = first_word;
                            n_chk    = 1'b0;
                            n_issued = 1'b0;
                            n_hit    = 1'b0;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_word;
                        n_state   = tsom_pkg::S_MODIFY;
                    end
                end
            end
            tsom_pkg::S_MODIFY: begin
                // for a mark, set the bit and count it if it was clear
                if ((r_kind == tsom_pkg::K_MARK) && !cur_bit) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_word;
                    ram_wdata = ram_rdata | (WORD_W'(1) << slot_bit);
                    n_count   = r_count + KW'(1);
                end
                n_state  = tsom_pkg::S_IDLE;
                n_done   = 1'b1;
                n_marked = (r_kind == tsom_pkg::K_MARK) || cur_bit;
                n_sid    = ix_id;
            end
            tsom_pkg::S_SCAN: begin
                // issue one word per cycle, check it the cycle after
                n_chk = 1'b0;
                if (!r_issued) begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_addr;
                    n_chk      = 1'b1;
                    n_chk_addr = r_addr;
                    if (r_addr == last_word) begin
                        n_issued = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_chk) begin
                    n_hit = r_hit || hit_now;
                    if (r_chk_addr == last_word) begin
                        n_state = tsom_pkg::S_IDLE;
                        n_done  = 1'b1;
                        n_empty = !(r_hit || hit_now);
                        n_sid   = ix_id;
                    end
                end
            end
            default: begin
                n_state = tsom_pkg::S_IDLE;
            end
        endcase

        n_full = n_valid && (CW'(n_count) == ix_prod);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tsom_pkg::S_WIPE;
            r_addr   <= '0;
            r_report <= 1'b0;
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_chk    <= 1'b0;
            r_issued <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_report <= n_report;
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_chk    <= n_chk;
            r_issued <= n_issued;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_pre_bad  <= n_pre_bad;
        r_hit      <= n_hit;
        r_chk_addr <= n_chk_addr;
        r_marked   <= n_marked;
        r_empty    <= n_empty;
        r_sid      <= n_sid;
        r_bad      <= n_bad;
        r_full     <= n_full;
    end

    assign o_busy         = r_state != tsom_pkg::S_IDLE;
    assign o_done         = r_done;
    assign o_slot_marked  = r_marked;
    assign o_range_empty  = r_empty;
    assign o_marked_count = 11'(r_count);
    assign o_all_full     = r_full;
    assign o_slot_id      = 10'(r_sid);
    assign o_bad_index    = r_bad;

endmodule

### hw/rtl/tsom_checker.sv
`include "tensor_slot_occupancy_map_macros.svh"

module tsom_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_slot_marked,
    input logic        o_range_empty,
    input logic [10:0] o_marked_count,
    input logic [9:0]  o_slot_id,
    input logic        o_bad_index
);

    // an accepted transaction either reports next cycle or keeps the block busy
    `TSOM_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done)

    // the block is free again while a result is shown
    `TSOM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_done, !o_busy)

    // a rejected transaction carries no slot, mark or empty flag
    `TSOM_ASSERT_NOW(a_bad_clean, i_clk, i_rst_n, o_done && o_bad_index, (o_slot_id == 10'd0) && !o_slot_marked && !o_range_empty)

    // a marked slot implies a nonzero count and no empty flag
    `TSOM_ASSERT_NOW(a_marked_count, i_clk, i_rst_n, o_done && o_slot_marked, (o_marked_count != 11'd0) && !o_range_empty)

endmodule

bind tensor_slot_occupancy_map tsom_checker u_tsom_checker (.*);

### test/tensor_slot_occupancy_map_tb.sv
`timescale 1ns / 100ps

module tensor_slot_occupancy_map_tb;

    localparam int MAP_DIMS      = 4;
    localparam int MAP_SLOTS     = 1024;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic        slot_marked;
        logic        range_empty;
        logic [10:0] marked_count;
        logic        all_full;
        logic [9:0]  slot_id;
        logic        bad_index;
    } t_map_result;

    // One line of the directed table: a register write or a request
    typedef struct packed {
        logic                is_reg;
        logic [2:0]          reg_index;
        logic [7:0]          reg_data;
        tsom_pkg::t_kind     kind;
        tsom_pkg::t_dim_vec  idx;
        logic [2:0]          plen;
        logic                typed;
        t_map_result         want;
    } t_stim_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_start      = 1'b0;
    logic [1:0]  i_kind       = tsom_pkg::K_MARK;
    logic [7:0]  i_index_0    = 8'd0;
    logic [7:0]  i_index_1    = 8'd0;
    logic [7:0]  i_index_2    = 8'd0;
    logic [7:0]  i_index_3    = 8'd0;
    logic [2:0]  i_prefix_len = 3'd1;
    logic        i_cfg_we     = 1'b0;
    logic [2:0]  i_cfg_index  = tsom_pkg::CFG_DIM_COUNT;
    logic [7:0]  i_cfg_data   = 8'd0;
    logic        o_busy;
    logic        o_done;
    logic        o_slot_marked;
    logic        o_range_empty;
    logic [10:0] o_marked_count;
    logic        o_all_full;
    logic [9:0]  o_slot_id;
    logic        o_bad_index;

    // Side band from the driver: a typed expectation for the current request
    logic        row_typed = 1'b0;
    t_map_result row_want  = '0;

    // Occupancy shadow and the results still owed by the block
    bit          occupied [MAP_SLOTS];
    logic [10:0] occupied_total;
    logic [2:0]  shadow_dims;
    logic [7:0]  shadow_size [MAP_DIMS];
    t_map_result pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    int unsigned idle_pct       = 0;
    bit          reg_port_open  = 1'b0;

    tensor_slot_occupancy_map dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_index_0      (i_index_0),
        .i_index_1      (i_index_1),
        .i_index_2      (i_index_2),
        .i_index_3      (i_index_3),
        .i_prefix_len   (i_prefix_len),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_slot_marked  (o_slot_marked),
        .o_range_empty  (o_range_empty),
        .o_marked_count (o_marked_count),
        .o_all_full     (o_all_full),
        .o_slot_id      (o_slot_id),
        .o_bad_index    (o_bad_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one request to the shadow map and return the result it owes
    function automatic t_map_result apply_request(input tsom_pkg::t_kind kind,
                                                  input tsom_pkg::t_dim_vec idx,
                                                  input logic [2:0] plen);
        t_map_result     res;
        int unsigned     active, n, i;
        longint unsigned prod, start, stride, j;
        bit              valid, bad;
        res    = '0;
        bad    = 1'b0;
        valid  = 1'b0;
        prod   = 0;
        active = (shadow_dims >= 1 && shadow_dims <= MAP_DIMS) ? shadow_dims : 0;
        if (active != 0) begin
            prod = 1;
            for (i = 0; i < active; i++) prod = prod * shadow_size[i];
            valid = (prod <= MAP_SLOTS);
        end
        if (kind == tsom_pkg::K_CLEAR) begin
            foreach (occupied[s]) occupied[s] = 1'b0;
            occupied_total = '0;
            bad = !valid;
        end else if (!valid) begin
            bad = 1'b1;
        end else begin
            n = (kind == tsom_pkg::K_PREFIX) ? plen : active;
            if (kind == tsom_pkg::K_PREFIX && (plen == 0 || plen > active)) bad = 1'b1;
            for (i = 0; i < n && !bad; i++)
                if (idx[i] >= shadow_size[i]) bad = 1'b1;
            if (!bad) begin
                // Row-major id, indices past the prefix taken as zero
                start = 0;
                for (i = 0; i < active; i++)
                    start = start * shadow_size[i] + ((i < n) ? idx[i] : 0);
                if (kind == tsom_pkg::K_PREFIX) begin
                    stride = 1;
                    for (i = n; i < active; i++) stride = stride * shadow_size[i];
                    res.range_empty = 1'b1;
                    for (j = start; j < start + stride && j < MAP_SLOTS; j++)
                        if (occupied[j]) res.range_empty = 1'b0;
                end else if (start < MAP_SLOTS) begin
                    if (kind == tsom_pkg::K_MARK && !occupied[start]) begin
                        occupied[start] = 1'b1;
                        occupied_total++;
                    end
                    res.slot_marked = occupied[start];
                end
                res.slot_id = 10'(start);
            end
        end
        res.marked_count = occupied_total;
        res.all_full     = valid && (occupied_total == prod);
        res.bad_index    = bad;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input t_map_result got, input t_map_result want);
        if (got.slot_marked !== want.slot_marked)
            report_mismatch($sformatf("slot_marked got %0b want %0b",
                                      got.slot_marked, want.slot_marked));
        if (got.range_empty !== want.range_empty)
            report_mismatch($sformatf("range_empty got %0b want %0b",
                                      got.range_empty, want.range_empty));
        if (got.marked_count !== want.marked_count)
            report_mismatch($sformatf("marked_count got %0d want %0d",
                                      got.marked_count, want.marked_count));
        if (got.all_full !== want.all_full)
            report_mismatch($sformatf("all_full got %0b want %0b",
                                      got.all_full, want.all_full));
        if (got.slot_id !== want.slot_id)
            report_mismatch($sformatf("slot_id got %0d want %0d", got.slot_id, want.slot_id));
        if (got.bad_index !== want.bad_index)
            report_mismatch($sformatf("bad_index got %0b want %0b",
                                      got.bad_index, want.bad_index));
    endtask

    // Watch the ports: check results, track writes, predict accepted requests
    always @(posedge i_clk) begin
        t_map_result got;
        t_map_result want;
        bit          moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            shadow_dims = 3'd1;
            foreach (shadow_size[d]) shadow_size[d] = 8'd1;
            foreach (occupied[s]) occupied[s] = 1'b0;
            occupied_total = '0;
            pending_results.delete();
            stall_cycles = 0;
        end else begin
            if (o_done) begin
                moved = 1'b1;
                got = '{slot_marked: o_slot_marked, range_empty: o_range_empty,
                        marked_count: o_marked_count, all_full: o_all_full,
                        slot_id: o_slot_id, bad_index: o_bad_index};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    want = pending_results.pop_front();
                    check_result(got, want);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tsom_pkg::CFG_DIM_COUNT:  shadow_dims    = i_cfg_data[2:0];
                    tsom_pkg::CFG_DIM_SIZE_0: shadow_size[0] = i_cfg_data;
                    tsom_pkg::CFG_DIM_SIZE_1: shadow_size[1] = i_cfg_data;
                    tsom_pkg::CFG_DIM_SIZE_2: shadow_size[2] = i_cfg_data;
                    tsom_pkg::CFG_DIM_SIZE_3: shadow_size[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                moved = 1'b1;
                want = apply_request(tsom_pkg::t_kind'(i_kind),
                                     {i_index_3, i_index_2, i_index_1, i_index_0},
                                     i_prefix_len);
                pending_results.insert(pending_results.size(), row_typed ? row_want : want);
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tensor_slot_occupancy_map regression: fail");
                $finish;
            end
        end
    end

    // Drop start and hold until every owed result is back and the block is idle
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
        if (!reg_port_open) begin
            wait_drained();
            reg_port_open = 1'b1;
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    task automatic close_reg_port();
        if (reg_port_open) begin
            i_cfg_we      <= 1'b0;
            reg_port_open  = 1'b0;
        end
    endtask

    // Present one request, with random idle cycles ahead of it, until accepted
    task automatic send_item(input tsom_pkg::t_kind kind, input tsom_pkg::t_dim_vec idx,
                             input logic [2:0] plen, input logic typed,
                             input t_map_result want);
        close_reg_port();
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_kind       <= kind;
        i_index_0    <= idx[0];
        i_index_1    <= idx[1];
        i_index_2    <= idx[2];
        i_index_3    <= idx[3];
        i_prefix_len <= plen;
        row_typed    <= typed;
        row_want     <= want;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic t_stim_row reg_row(input logic [2:0] index, input logic [7:0] data);
        t_stim_row row;
        row           = '0;
        row.is_reg    = 1'b1;
        row.reg_index = index;
        row.reg_data  = data;
        return row;
    endfunction

    function automatic t_stim_row item_row(input tsom_pkg::t_kind kind,
                                           input logic [7:0] i0, i1, i2, i3,
                                           input logic [2:0] plen);
        t_stim_row row;
        row        = '0;
        row.kind   = kind;
        row.idx[0] = i0;
        row.idx[1] = i1;
        row.idx[2] = i2;
        row.idx[3] = i3;
        row.plen   = plen;
        return row;
    endfunction

    function automatic t_stim_row known_row(input tsom_pkg::t_kind kind,
                                            input logic [7:0] i0, i1, i2, i3,
                                            input logic [2:0] plen, input logic marked, empty,
                                            input logic [10:0] count, input logic full,
                                            input logic [9:0] id, input logic bad);
        t_stim_row row;
        row       = item_row(kind, i0, i1, i2, i3, plen);
        row.typed = 1'b1;
        row.want  = '{marked, empty, count, full, id, bad};
        return row;
    endfunction

    initial begin : stimulus
        t_stim_row           directed_rows [0:39];
        tsom_pkg::t_dim_vec  idx;
        tsom_pkg::t_kind     kind;
        logic [2:0]          plen;
        logic [2:0]          dims;
        logic [7:0]          sizes [MAP_DIMS];
        int unsigned         exps [MAP_DIMS];
        int unsigned         r, j, k, pick, live, size_cap, burst, phase, random_sent;

        directed_rows = '{
            // reset shape: one dimension of one slot
            known_row(tsom_pkg::K_TEST,   0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 0, 1, 1, 0, 1, 1, 0, 0),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 0, 1, 1, 0, 1, 1, 0, 0),
            known_row(tsom_pkg::K_MARK,   1, 0, 0, 0, 1, 0, 0, 1, 1, 0, 1),
            known_row(tsom_pkg::K_PREFIX, 0, 0, 0, 0, 1, 0, 0, 1, 1, 0, 0),
            known_row(tsom_pkg::K_PREFIX, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1),
            known_row(tsom_pkg::K_PREFIX, 0, 0, 0, 0, 2, 0, 0, 1, 1, 0, 1),
            known_row(tsom_pkg::K_CLEAR,  0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0),
            // full capacity grid 4 x 4 x 8 x 8
            reg_row(tsom_pkg::CFG_DIM_COUNT, 8'd4),
            reg_row(tsom_pkg::CFG_DIM_SIZE_0, 8'd4),
            reg_row(tsom_pkg::CFG_DIM_SIZE_1, 8'd4),
            reg_row(tsom_pkg::CFG_DIM_SIZE_2, 8'd8),
            reg_row(tsom_pkg::CFG_DIM_SIZE_3, 8'd8),
            known_row(tsom_pkg::K_MARK,   3, 3, 7, 7, 4, 1, 0, 1, 0, 1023, 0),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 0, 4, 1, 0, 2, 0, 0, 0),
            known_row(tsom_pkg::K_TEST,   255, 255, 255, 255, 4, 0, 0, 2, 0, 0, 1),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 8, 4, 0, 0, 2, 0, 0, 1),
            known_row(tsom_pkg::K_PREFIX, 3, 3, 7, 7, 4, 0, 0, 2, 0, 1023, 0),
            item_row(tsom_pkg::K_PREFIX,  1, 0, 0, 0, 1),
            item_row(tsom_pkg::K_PREFIX,  0, 0, 0, 0, 1),
            known_row(tsom_pkg::K_PREFIX, 0, 0, 0, 0, 5, 0, 0, 2, 0, 0, 1),
            // unusable dimension counts; clear still wipes
            reg_row(tsom_pkg::CFG_DIM_COUNT, 8'd0),
            known_row(tsom_pkg::K_TEST,   0, 0, 0, 0, 1, 0, 0, 2, 0, 0, 1),
            known_row(tsom_pkg::K_CLEAR,  0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1),
            reg_row(tsom_pkg::CFG_DIM_COUNT, 8'd7),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1),
            // shape product above capacity
            reg_row(tsom_pkg::CFG_DIM_COUNT, 8'd2),
            reg_row(tsom_pkg::CFG_DIM_SIZE_0, 8'd255),
            reg_row(tsom_pkg::CFG_DIM_SIZE_1, 8'd255),
            known_row(tsom_pkg::K_MARK,   0, 0, 0, 0, 2, 0, 0, 0, 0, 0, 1),
            known_row(tsom_pkg::K_PREFIX, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1),
            // zero-size dimension: empty grid reads as full
            reg_row(tsom_pkg::CFG_DIM_SIZE_0, 8'd0),
            known_row(tsom_pkg::K_TEST,   0, 0, 0, 0, 2, 0, 0, 0, 1, 0, 1),
            known_row(tsom_pkg::K_CLEAR,  0, 0, 0, 0, 2, 0, 0, 0, 1, 0, 0),
            reg_row(tsom_pkg::CFG_DIM_COUNT, 8'd3),
            reg_row(tsom_pkg::CFG_DIM_SIZE_0, 8'd2),
            reg_row(tsom_pkg::CFG_DIM_SIZE_1, 8'd0),
            reg_row(tsom_pkg::CFG_DIM_SIZE_2, 8'd4),
            item_row(tsom_pkg::K_PREFIX,  1, 0, 0, 0, 1),
            known_row(tsom_pkg::K_MARK,   1, 0, 0, 0, 3, 0, 0, 0, 1, 0, 1)
        };

        // Hold reset, then release on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling
        idle_pct = 0;
        for (r = 0; r < $size(directed_rows); r++) begin
            if (directed_rows[r].is_reg)
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_data);
            else
                send_item(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].plen,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        // Random phases, each with a fresh shape and its own idling mix
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            dims = 3'($urandom_range(1, 4));
            for (j = 0; j < MAP_DIMS; j++) sizes[j] = 8'($urandom_range(0, 255));
            case (dims)
                3'd1:    size_cap = 12;
                3'd2:    size_cap = 4;
                3'd3:    size_cap = 3;
                default: size_cap = 2;
            endcase
            for (j = 0; j < dims; j++) sizes[j] = 8'($urandom_range(1, size_cap));
            case ($urandom_range(0, 9))
                0: begin
                    // unusable count, or a product past capacity
                    if ($urandom_range(0, 1) != 0) begin
                        pick = $urandom_range(5, 8);
                        dims = 3'((pick == 8) ? 0 : pick);
                    end else begin
                        dims = 3'($urandom_range(2, 4));
                        for (j = 0; j < dims; j++) sizes[j] = 8'($urandom_range(33, 255));
                    end
                end
                1: sizes[$urandom_range(0, dims - 1)] = 8'd0;
                2: begin
                    // powers of two that fill the whole map
                    dims = 3'($urandom_range(2, 4));
                    for (j = 0; j < MAP_DIMS; j++) exps[j] = 0;
                    for (k = 0; k < 10; k++) begin
                        do pick = $urandom_range(0, dims - 1); while (exps[pick] == 7);
                        exps[pick]++;
                    end
                    for (j = 0; j < dims; j++) sizes[j] = 8'(1 << exps[j]);
                end
                default: ;
            endcase
            write_reg(tsom_pkg::CFG_DIM_COUNT, {5'd0, dims});
            write_reg(tsom_pkg::CFG_DIM_SIZE_0, sizes[0]);
            write_reg(tsom_pkg::CFG_DIM_SIZE_1, sizes[1]);
            write_reg(tsom_pkg::CFG_DIM_SIZE_2, sizes[2]);
            write_reg(tsom_pkg::CFG_DIM_SIZE_3, sizes[3]);

            case (phase % 4)
                1:       idle_pct = 48;
                3:       idle_pct = 30;
                default: idle_pct = 0;
            endcase
            live  = (dims >= 1 && dims <= MAP_DIMS) ? dims : MAP_DIMS;
            burst = $urandom_range(60, 140);
            for (k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) == 0) wait_drained();
                r = $urandom_range(0, 99);
                if (r < 50)      kind = tsom_pkg::K_MARK;
                else if (r < 70) kind = tsom_pkg::K_TEST;
                else if (r < 98) kind = tsom_pkg::K_PREFIX;
                else             kind = tsom_pkg::K_CLEAR;
                // mostly in-range indices; the rest anywhere in the field
                for (j = 0; j < MAP_DIMS; j++) begin
                    if (j < live && sizes[j] != 0 && $urandom_range(0, 9) != 0)
                        idx[j] = 8'($urandom_range(0, sizes[j] - 1));
                    else
                        idx[j] = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 6) != 0) plen = 3'($urandom_range(1, live));
                else                           plen = 3'($urandom_range(0, 7));
                send_item(kind, idx, plen, 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        // Drain, let the pipeline settle, then judge
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0) begin
            $display("tensor_slot_occupancy_map regression: pass");
        end else begin
            $display("tensor_slot_occupancy_map regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tsom_pkg.sv
hw/rtl/tsom_ram.sv
hw/rtl/tsom_index.sv
hw/rtl/tensor_slot_occupancy_map.sv
hw/rtl/tsom_checker.sv
test/tensor_slot_occupancy_map_tb.sv
